// File: rtl/trc_pkg.sv
// shared types, register indexes and constants of the threat reflex controller
`default_nettype none

package trc_pkg;

    localparam int NODE_COUNT_DEF = 8;

    localparam int HOLD_W = 20;
    localparam int SEQ_W  = 32;
    localparam int BYTE_W = 8;

    // event kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_LOCAL = 2'd1;
    localparam logic [1:0] KIND_ALARM = 2'd2;

    // threat classes
    localparam logic [7:0] CLASS_NORMAL   = 8'd0;
    localparam logic [7:0] CLASS_CRITICAL = 8'd2;

    localparam logic [7:0] CONF_UNKNOWN = 8'hFF;
    localparam logic [7:0] STREAK_MAX   = 8'd255;

    // register indexes
    localparam logic [2:0] REG_ENABLE       = 3'd0;
    localparam logic [2:0] REG_OWN_NODE     = 3'd1;
    localparam logic [2:0] REG_HOLD_TICKS   = 3'd2;
    localparam logic [2:0] REG_CONF_MIN     = 3'd3;
    localparam logic [2:0] REG_STREAK_MIN   = 3'd4;
    localparam logic [2:0] REG_CONSERVE_LVL = 3'd5;
    localparam logic [2:0] REG_HOP_LIMIT    = 3'd6;
    localparam logic [2:0] REG_ALARM_MAGIC  = 3'd7;

    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 20'd10000;
    localparam logic [7:0]        CONF_MIN_RST   = 8'd128;
    localparam logic [7:0]        STREAK_MIN_RST = 8'd2;
    localparam logic [7:0]        CONS_LVL_RST   = 8'd1;
    localparam logic [7:0]        HOP_LIMIT_RST  = 8'd1;

    typedef struct packed {
        logic              enable;
        logic [7:0]        own_node;
        logic [HOLD_W-1:0] hold_ticks;
        logic [7:0]        confidence_min;
        logic [7:0]        shield_streak_min;
        logic [7:0]        conserve_level;
        logic [7:0]        hop_limit;
        logic [SEQ_W-1:0]  alarm_magic;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       event_class;
        logic [7:0]       confidence;
        logic [7:0]       source_id;
        logic [SEQ_W-1:0] alarm_seq;
        logic [7:0]       hop;
        logic [SEQ_W-1:0] magic;
    } req_t;

    typedef struct packed {
        logic             shield_active;
        logic [7:0]       pressure_bias;
        logic             fired;
        logic             did_shield;
        logic             did_conserve;
        logic             beacon_valid;
        logic [SEQ_W-1:0] beacon_seq;
        logic [7:0]       beacon_class;
        logic [7:0]       beacon_confidence;
        logic [7:0]       beacon_hop;
        logic [1:0]       released;
        logic             alarm_accepted;
    } rsp_t;

endpackage

`default_nettype wire

// File: rtl/trc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module trc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/trc_cfg.sv
// configuration register file
`default_nettype none

module trc_cfg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    output trc_pkg::cfg_t             cfg,
    output logic                      hold_clear
);

    trc_pkg::cfg_t cfg_reg;
    trc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                trc_pkg::REG_ENABLE:       cfg_next.enable = cfg_data[0];
                trc_pkg::REG_OWN_NODE:     cfg_next.own_node = cfg_data[7:0];
                trc_pkg::REG_HOLD_TICKS:
                    cfg_next.hold_ticks = cfg_data[trc_pkg::HOLD_W-1:0];
                trc_pkg::REG_CONF_MIN:     cfg_next.confidence_min = cfg_data[7:0];
                trc_pkg::REG_STREAK_MIN:   cfg_next.shield_streak_min = cfg_data[7:0];
                trc_pkg::REG_CONSERVE_LVL: cfg_next.conserve_level = cfg_data[7:0];
                trc_pkg::REG_HOP_LIMIT:    cfg_next.hop_limit = cfg_data[7:0];
                trc_pkg::REG_ALARM_MAGIC:  cfg_next.alarm_magic = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= 1'b1;
            cfg_reg.own_node          <= '0;
            cfg_reg.hold_ticks        <= trc_pkg::HOLD_TICKS_RST;
            cfg_reg.confidence_min    <= trc_pkg::CONF_MIN_RST;
            cfg_reg.shield_streak_min <= trc_pkg::STREAK_MIN_RST;
            cfg_reg.conserve_level    <= trc_pkg::CONS_LVL_RST;
            cfg_reg.hop_limit         <= trc_pkg::HOP_LIMIT_RST;
            cfg_reg.alarm_magic       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg        = cfg_reg;
    assign hold_clear = cfg_wr_en && (cfg_index == trc_pkg::REG_ENABLE) && !cfg_data[0];

endmodule

`default_nettype wire

// File: rtl/trc_peer_table.sv
// per-peer last alarm sequence table with valid bits and write forwarding
`default_nettype none

module trc_peer_table #(
    parameter int NODE_COUNT = trc_pkg::NODE_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0] rd_addr,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0] wr_addr,
    input  wire logic [trc_pkg::SEQ_W-1:0]     wr_data,
    output logic      [trc_pkg::SEQ_W-1:0]     last_seq
);

    localparam int IDX_W = $clog2(NODE_COUNT);

    logic [NODE_COUNT-1:0]     vld_reg;
    logic                      hit_reg;
    logic                      fwd_reg;
    logic [trc_pkg::SEQ_W-1:0] fwd_data_reg;
    logic [trc_pkg::SEQ_W-1:0] ram_rd_data;
    logic                      rd_in_range;

    trc_ram #(
        .WIDTH (trc_pkg::SEQ_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_in_range = ({1'b0, rd_addr} < (IDX_W + 1)'(NODE_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                // write landing on the same entry at this edge wins over the ram
                hit_reg <= rd_in_range && vld_reg[rd_addr];
                fwd_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            last_seq = fwd_data_reg;
        end
        else if (hit_reg)
        begin
            last_seq = ram_rd_data;
        end
        else
        begin
            last_seq = '0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/trc_core.sv
// event evaluation, hold countdowns, critical streak and beacon counter
`default_nettype none

module trc_core #(
    parameter int NODE_COUNT = trc_pkg::NODE_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire trc_pkg::cfg_t                 cfg,
    input  wire logic                          hold_clear,
    input  wire logic                          step_en,
    input  wire trc_pkg::req_t                 req,
    input  wire logic [trc_pkg::SEQ_W-1:0]     last_seq,
    output logic                               peer_wr_en,
    output logic      [$clog2(NODE_COUNT)-1:0] peer_wr_addr,
    output trc_pkg::rsp_t                      rsp
);

    localparam int         IDX_W      = $clog2(NODE_COUNT);
    localparam logic [7:0] NODE_LIMIT = 8'(NODE_COUNT);

    logic [trc_pkg::HOLD_W-1:0] shield_left_reg;
    logic [trc_pkg::HOLD_W-1:0] shield_left_next;
    logic [trc_pkg::HOLD_W-1:0] conserve_left_reg;
    logic [trc_pkg::HOLD_W-1:0] conserve_left_next;
    logic [7:0]                 streak_reg;
    logic [7:0]                 streak_next;
    logic [trc_pkg::SEQ_W-1:0]  beacon_cnt_reg;
    logic [trc_pkg::SEQ_W-1:0]  beacon_cnt_next;

    logic alarm_ok;
    logic alarm_dup;
    logic local_pass;

    assign peer_wr_addr = req.source_id[IDX_W-1:0];

    always_comb
    begin
        shield_left_next   = shield_left_reg;
        conserve_left_next = conserve_left_reg;
        streak_next        = streak_reg;
        beacon_cnt_next    = beacon_cnt_reg;
        peer_wr_en         = 1'b0;
        rsp                = '0;

        alarm_ok  = (req.magic == cfg.alarm_magic) && (req.source_id < NODE_LIMIT)
                    && (req.source_id != cfg.own_node);
        alarm_dup = (last_seq == req.alarm_seq) && (last_seq != '0);
        local_pass = (req.confidence == trc_pkg::CONF_UNKNOWN)
                     || (req.confidence >= cfg.confidence_min);

        if (!cfg.enable)
        begin
            shield_left_next   = '0;
            conserve_left_next = '0;
        end
        else
        begin
            case (req.kind)
                trc_pkg::KIND_TICK:
                begin
                    if (shield_left_reg != '0)
                    begin
                        shield_left_next = shield_left_reg - 20'd1;
                        if (shield_left_next == '0)
                        begin
                            rsp.released[0] = 1'b1;
                            streak_next     = '0;
                        end
                    end
                    if (conserve_left_reg != '0)
                    begin
                        conserve_left_next = conserve_left_reg - 20'd1;
                        if (conserve_left_next == '0)
                        begin
                            rsp.released[1] = 1'b1;
                        end
                    end
                end
                trc_pkg::KIND_LOCAL:
                begin
                    if (req.event_class <= trc_pkg::CLASS_CRITICAL)
                    begin
                        if (req.event_class == trc_pkg::CLASS_CRITICAL)
                        begin
                            if (streak_reg < trc_pkg::STREAK_MAX)
                            begin
                                streak_next = streak_reg + 8'd1;
                            end
                        end
                        else if (req.event_class == trc_pkg::CLASS_NORMAL)
                        begin
                            streak_next = '0;
                        end
                        if ((req.event_class != trc_pkg::CLASS_NORMAL) && local_pass)
                        begin
                            rsp.fired = 1'b1;
                            if ((req.event_class == trc_pkg::CLASS_CRITICAL)
                                && (streak_next >= cfg.shield_streak_min))
                            begin
                                shield_left_next = cfg.hold_ticks;
                                rsp.did_shield   = 1'b1;
                            end
                            conserve_left_next    = cfg.hold_ticks;
                            rsp.did_conserve      = 1'b1;
                            beacon_cnt_next       = beacon_cnt_reg + 32'd1;
                            rsp.beacon_valid      = 1'b1;
                            rsp.beacon_seq        = beacon_cnt_next;
                            rsp.beacon_class      = req.event_class;
                            rsp.beacon_confidence = req.confidence;
                            rsp.beacon_hop        = cfg.hop_limit;
                        end
                    end
                end
                trc_pkg::KIND_ALARM:
                begin
                    if (alarm_ok && !alarm_dup)
                    begin
                        peer_wr_en         = 1'b1;
                        rsp.alarm_accepted = 1'b1;
                        if (req.event_class != trc_pkg::CLASS_NORMAL)
                        begin
                            conserve_left_next = cfg.hold_ticks;
                            rsp.did_conserve   = 1'b1;
                            if (req.hop != '0)
                            begin
                                beacon_cnt_next       = beacon_cnt_reg + 32'd1;
                                rsp.beacon_valid      = 1'b1;
                                rsp.beacon_seq        = beacon_cnt_next;
                                rsp.beacon_class      = req.event_class;
                                rsp.beacon_confidence = req.confidence;
                                rsp.beacon_hop        = req.hop - 8'd1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            rsp.shield_active = (shield_left_next != '0);
            rsp.pressure_bias = (conserve_left_next != '0) ? cfg.conserve_level : '0;
        end

        peer_wr_en = peer_wr_en && step_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shield_left_reg   <= '0;
            conserve_left_reg <= '0;
            streak_reg        <= '0;
            beacon_cnt_reg    <= '0;
        end
        else if (hold_clear)
        begin
            shield_left_reg   <= '0;
            conserve_left_reg <= '0;
        end
        else if (step_en)
        begin
            shield_left_reg   <= shield_left_next;
            conserve_left_reg <= conserve_left_next;
            streak_reg        <= streak_next;
            beacon_cnt_reg    <= beacon_cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/threat_reflex_controller_unit.sv
// Threat reflex controller: takes one request per clock (tick, local verdict or peer
// alarm) unless a stalled result holds it back, and returns exactly one result per request.
// A request is held in the input register, where the peer sequence memory is read with
// the request's source node, and is evaluated into the result register when the result
// register is empty or its result is taken; with out_ready high the sustained rate is
// one request per cycle, with one peer table read per request. While a result waits on
// out_ready the input register holds at most one further request and in_ready then drops.
// The peer table needs no clearing pass after reset.
// Configuration writes take effect at once and must only be issued while no request is
// in flight; writing enable to 0 clears both hold countdowns.
`default_nettype none

module threat_reflex_controller_unit #(
    parameter int NODE_COUNT = trc_pkg::NODE_COUNT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire trc_pkg::req_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output trc_pkg::rsp_t      out_data,
    input  wire logic          cfg_wr_en,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int IDX_W = $clog2(NODE_COUNT);

    trc_pkg::cfg_t             cfg;
    logic                      hold_clear;
    logic                      req_valid_reg;
    trc_pkg::req_t             req_reg;
    logic                      out_valid_reg;
    trc_pkg::rsp_t             out_data_reg;
    trc_pkg::rsp_t             rsp;
    logic                      advance;
    logic                      accept;
    logic                      peer_wr_en;
    logic [IDX_W-1:0]          peer_wr_addr;
    logic [trc_pkg::SEQ_W-1:0] last_seq;

    assign advance  = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    trc_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .hold_clear (hold_clear)
    );

    trc_peer_table #(
        .NODE_COUNT (NODE_COUNT)
    ) u_peer_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (in_data.source_id[IDX_W-1:0]),
        .wr_en    (peer_wr_en),
        .wr_addr  (peer_wr_addr),
        .wr_data  (req_reg.alarm_seq),
        .last_seq (last_seq)
    );

    trc_core #(
        .NODE_COUNT (NODE_COUNT)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .hold_clear   (hold_clear),
        .step_en      (advance),
        .req          (req_reg),
        .last_seq     (last_seq),
        .peer_wr_en   (peer_wr_en),
        .peer_wr_addr (peer_wr_addr),
        .rsp          (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/trc_checker.sv
// port-level checks of the threat reflex controller and their binding
`default_nettype none

module trc_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire trc_pkg::req_t in_data,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire trc_pkg::rsp_t out_data,
    input wire logic          cfg_wr_en,
    input wire logic [2:0]    cfg_index,
    input wire logic [31:0]   cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // beacon fields are zero without a beacon
    a_beacon_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.beacon_valid |->
            out_data.beacon_seq == '0 && out_data.beacon_class == '0
            && out_data.beacon_confidence == '0 && out_data.beacon_hop == '0)
        else $error("beacon fields set without beacon");

    // shield engagement only by a fired local verdict
    a_shield_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.did_shield |-> out_data.fired && out_data.did_conserve
            && out_data.beacon_valid)
        else $error("shield engaged without firing");

    // a peer alarm never shares a result with a local verdict or a release
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.alarm_accepted |-> !out_data.fired && out_data.released == '0)
        else $error("alarm result mixed with other event");

    // a release comes only from a tick
    a_release_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.released != '0 |-> !out_data.did_conserve
            && !out_data.beacon_valid)
        else $error("release mixed with engagement");

endmodule

bind threat_reflex_controller_unit trc_checker u_trc_checker (.*);

`default_nettype wire
